// ----- src/glos_pkg.sv -----
`default_nettype none

package glos_pkg;

  localparam int unsigned MAX_COLS = 256;
  localparam int unsigned MAX_ROWS = 256;
  localparam int unsigned COL_AW = $clog2(MAX_COLS);
  localparam int unsigned ROW_AW = $clog2(MAX_ROWS);

  localparam int unsigned VERT_W = 9;
  localparam int unsigned CRD_W = VERT_W + 2;
  localparam int unsigned ERR_W = VERT_W + 1;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic signed [CRD_W-1:0] CRD_ONE = CRD_W'(1);
  localparam logic signed [CRD_W-1:0] CRD_ZERO = CRD_W'(0);
  localparam logic signed [CRD_W-1:0] CRD_MONE = {CRD_W{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_MOD,
    S_DIAG,
    S_MAIN,
    S_SIDE0,
    S_SIDE1,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- src/grid_line_of_sight.sv -----
// A cell write reads its map row, modifies it and writes it back, then returns its acknowledge.
// A query walks the line one major-axis step at a time, one map row read per cell test.
// The single read port of the row memory paces the walk; one item is worked on at a time.
// A new item is taken while the previous result still waits on the master side.
// After reset the map is cleared one row per cycle, all MAX_ROWS rows, before any input transfer.
`default_nettype none

module grid_line_of_sight (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // x_a [8:0], y_a [17:9], x_b [26:18], y_b [35:27], blocked_value [36], zeros above.
  input  wire logic [glos_pkg::IN_TDATA_W-1:0]        s_axis_tdata_i,
  // operation [0].
  input  wire logic                                   s_axis_tuser_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // line_clear [0], zeros above.
  output logic [glos_pkg::OUT_TDATA_W-1:0]            m_axis_tdata_o,
  // answer_is_query [0].
  output logic                                        m_axis_tuser_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [glos_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [glos_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned VW = glos_pkg::VERT_W;
  localparam int unsigned CW = glos_pkg::CRD_W;

  logic [glos_pkg::MAX_COLS-1:0] map_mem [glos_pkg::MAX_ROWS];
  logic [glos_pkg::MAX_COLS-1:0] rdata_q;
  logic [glos_pkg::ROW_AW-1:0]   rd_addr;
  logic                          mem_we;
  logic [glos_pkg::ROW_AW-1:0]   mem_waddr;
  logic [glos_pkg::MAX_COLS-1:0] mem_wdata;

  glos_pkg::state_e state_q, state_d;
  logic [glos_pkg::ROW_AW-1:0] clr_q, clr_d;
  logic wait_q, wait_d;
  logic out_valid_q, out_valid_d;
  logic out_clear_q, out_clear_d;
  logic out_query_q, out_query_d;
  logic [glos_pkg::CFG_DATA_W-1:0] grid_cols_q, grid_rows_q;

  logic res_clear_q, res_clear_d;
  logic res_query_q, res_query_d;
  logic major_x_q, major_x_d;
  logic sa_neg_q, sa_neg_d;
  logic sb_neg_q, sb_neg_d;
  logic signed [CW-1:0] a_q, a_d;
  logic signed [CW-1:0] b_q, b_d;
  logic signed [CW-1:0] a_end_q, a_end_d;
  logic [VW-1:0] dmaj_q, dmaj_d;
  logic [VW-1:0] dmin_q, dmin_d;
  logic [glos_pkg::ERR_W-1:0] err_q, err_d;
  logic [glos_pkg::COL_AW-1:0] probe_col_q, probe_col_d;
  logic [glos_pkg::ROW_AW-1:0] wr_row_q, wr_row_d;
  logic [glos_pkg::COL_AW-1:0] wr_col_q, wr_col_d;
  logic wr_bit_q, wr_bit_d;

  logic [VW-1:0] in_xa, in_ya, in_xb, in_yb;
  logic          in_bit;
  logic          s_accept;

  logic signed [CW-1:0] xa_s, ya_s, xb_s, yb_s;
  logic signed [CW-1:0] dx_s, dy_s, adx_s, ady_s;
  logic                 q_major_x;
  logic                 wr_in_grid;

  logic [glos_pkg::ERR_W-1:0] err_sum;
  logic                       diag_need;
  logic signed [CW-1:0]       ca, cb, cx, cy, a_next;
  logic                       in_grid;
  logic                       probe_need;
  logic                       probe_issue;
  logic                       blk;

  assign in_xa  = s_axis_tdata_i[VW-1:0];
  assign in_ya  = s_axis_tdata_i[2*VW-1:VW];
  assign in_xb  = s_axis_tdata_i[3*VW-1:2*VW];
  assign in_yb  = s_axis_tdata_i[4*VW-1:3*VW];
  assign in_bit = s_axis_tdata_i[4*VW];

  assign s_axis_tready_o = (state_q == glos_pkg::S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(glos_pkg::OUT_TDATA_W-1){1'b0}}, out_clear_q};
  assign m_axis_tuser_o  = out_query_q;

  always_comb begin
    xa_s  = CW'(in_xa);
    ya_s  = CW'(in_ya);
    xb_s  = CW'(in_xb);
    yb_s  = CW'(in_yb);
    dx_s  = xb_s - xa_s;
    dy_s  = yb_s - ya_s;
    adx_s = dx_s[CW-1] ? -dx_s : dx_s;
    ady_s = dy_s[CW-1] ? -dy_s : dy_s;
    q_major_x = (adx_s >= ady_s);
    wr_in_grid = (in_xa < grid_cols_q) && (int'(in_xa) < glos_pkg::MAX_COLS) &&
                 (in_ya < grid_rows_q) && (int'(in_ya) < glos_pkg::MAX_ROWS);
  end

  always_comb begin
    err_sum   = err_q + glos_pkg::ERR_W'(dmin_q);
    diag_need = (err_sum >= glos_pkg::ERR_W'(dmaj_q));
    ca = a_q + (sa_neg_q ? glos_pkg::CRD_MONE : glos_pkg::CRD_ZERO);
    case (state_q)
      glos_pkg::S_SIDE0: cb = b_q;
      glos_pkg::S_SIDE1: cb = b_q + glos_pkg::CRD_MONE;
      default:           cb = b_q + (sb_neg_q ? glos_pkg::CRD_MONE : glos_pkg::CRD_ZERO);
    endcase
    cx = major_x_q ? ca : cb;
    cy = major_x_q ? cb : ca;
    in_grid = !cx[CW-1] && !cy[CW-1] &&
              (cx < signed'(CW'(grid_cols_q))) && (int'(cx) < glos_pkg::MAX_COLS) &&
              (cy < signed'(CW'(grid_rows_q))) && (int'(cy) < glos_pkg::MAX_ROWS);
    case (state_q)
      glos_pkg::S_DIAG:  probe_need = diag_need;
      glos_pkg::S_MAIN:  probe_need = (err_q != '0);
      glos_pkg::S_SIDE0: probe_need = 1'b1;
      glos_pkg::S_SIDE1: probe_need = 1'b1;
      default:           probe_need = 1'b0;
    endcase
    probe_issue = !wait_q && probe_need && in_grid;
    blk    = wait_q ? rdata_q[probe_col_q] : 1'b1;
    a_next = a_q + (sa_neg_q ? glos_pkg::CRD_MONE : glos_pkg::CRD_ONE);
  end

  always_comb begin
    logic advance;
    logic fail;
    advance = 1'b0;
    fail    = 1'b0;

    state_d     = state_q;
    clr_d       = clr_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_clear_d = out_clear_q;
    out_query_d = out_query_q;
    res_clear_d = res_clear_q;
    res_query_d = res_query_q;
    major_x_d   = major_x_q;
    sa_neg_d    = sa_neg_q;
    sb_neg_d    = sb_neg_q;
    a_d         = a_q;
    b_d         = b_q;
    a_end_d     = a_end_q;
    dmaj_d      = dmaj_q;
    dmin_d      = dmin_q;
    err_d       = err_q;
    probe_col_d = probe_col_q;
    wr_row_d    = wr_row_q;
    wr_col_d    = wr_col_q;
    wr_bit_d    = wr_bit_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_row_q;
    mem_wdata   = rdata_q;
    rd_addr     = glos_pkg::ROW_AW'(cy);

    case (state_q)
      glos_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + glos_pkg::ROW_AW'(1);
        if (clr_q == glos_pkg::ROW_AW'(glos_pkg::MAX_ROWS - 1)) begin
          state_d = glos_pkg::S_IDLE;
        end
      end
      glos_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          wait_d = 1'b0;
          if (s_axis_tuser_i == glos_pkg::OP_WRITE) begin
            res_clear_d = 1'b0;
            res_query_d = 1'b0;
            wr_row_d    = glos_pkg::ROW_AW'(in_ya);
            wr_col_d    = glos_pkg::COL_AW'(in_xa);
            wr_bit_d    = in_bit;
            rd_addr     = glos_pkg::ROW_AW'(in_ya);
            state_d     = wr_in_grid ? glos_pkg::S_WR_MOD : glos_pkg::S_DONE;
          end else begin
            res_query_d = 1'b1;
            major_x_d   = q_major_x;
            a_d         = q_major_x ? xa_s : ya_s;
            b_d         = q_major_x ? ya_s : xa_s;
            a_end_d     = q_major_x ? xb_s : yb_s;
            sa_neg_d    = q_major_x ? dx_s[CW-1] : dy_s[CW-1];
            sb_neg_d    = q_major_x ? dy_s[CW-1] : dx_s[CW-1];
            dmaj_d      = q_major_x ? adx_s[VW-1:0] : ady_s[VW-1:0];
            dmin_d      = q_major_x ? ady_s[VW-1:0] : adx_s[VW-1:0];
            err_d       = '0;
            if (adx_s == glos_pkg::CRD_ZERO && ady_s == glos_pkg::CRD_ZERO) begin
              res_clear_d = 1'b1;
              state_d     = glos_pkg::S_DONE;
            end else begin
              state_d = glos_pkg::S_DIAG;
            end
          end
        end
      end
      glos_pkg::S_WR_MOD: begin
        mem_we    = 1'b1;
        mem_waddr = wr_row_q;
        mem_wdata = rdata_q;
        mem_wdata[wr_col_q] = wr_bit_q;
        state_d   = glos_pkg::S_DONE;
      end
      glos_pkg::S_DIAG, glos_pkg::S_MAIN, glos_pkg::S_SIDE0, glos_pkg::S_SIDE1: begin
        if (probe_issue) begin
          wait_d      = 1'b1;
          probe_col_d = glos_pkg::COL_AW'(cx);
        end else begin
          wait_d = 1'b0;
          case (state_q)
            glos_pkg::S_DIAG: begin
              if (probe_need) begin
                if (blk) begin
                  fail = 1'b1;
                end else begin
                  b_d     = b_q + (sb_neg_q ? glos_pkg::CRD_MONE : glos_pkg::CRD_ONE);
                  err_d   = err_sum - glos_pkg::ERR_W'(dmaj_q);
                  state_d = glos_pkg::S_MAIN;
                end
              end else begin
                err_d   = err_sum;
                state_d = glos_pkg::S_MAIN;
              end
            end
            glos_pkg::S_MAIN: begin
              if (probe_need && blk) begin
                fail = 1'b1;
              end else if (dmin_q == '0) begin
                state_d = glos_pkg::S_SIDE0;
              end else begin
                advance = 1'b1;
              end
            end
            glos_pkg::S_SIDE0: begin
              if (blk) begin
                state_d = glos_pkg::S_SIDE1;
              end else begin
                advance = 1'b1;
              end
            end
            default: begin
              if (blk) begin
                fail = 1'b1;
              end else begin
                advance = 1'b1;
              end
            end
          endcase
        end
        if (fail) begin
          res_clear_d = 1'b0;
          state_d     = glos_pkg::S_DONE;
        end else if (advance) begin
          a_d = a_next;
          if (a_next == a_end_q) begin
            res_clear_d = 1'b1;
            state_d     = glos_pkg::S_DONE;
          end else begin
            state_d = glos_pkg::S_DIAG;
          end
        end
      end
      glos_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_clear_d = res_clear_q;
          out_query_d = res_query_q;
          state_d     = glos_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = glos_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= map_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= glos_pkg::S_CLEAR;
      clr_q       <= '0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      grid_cols_q <= glos_pkg::CFG_DATA_W'(256);
      grid_rows_q <= glos_pkg::CFG_DATA_W'(256);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == glos_pkg::REG_GRID_COLS) begin
          grid_cols_q <= cfg_data_i;
        end else if (cfg_index_i == glos_pkg::REG_GRID_ROWS) begin
          grid_rows_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_clear_q <= out_clear_d;
    out_query_q <= out_query_d;
    res_clear_q <= res_clear_d;
    res_query_q <= res_query_d;
    major_x_q   <= major_x_d;
    sa_neg_q    <= sa_neg_d;
    sb_neg_q    <= sb_neg_d;
    a_q         <= a_d;
    b_q         <= b_d;
    a_end_q     <= a_end_d;
    dmaj_q      <= dmaj_d;
    dmin_q      <= dmin_d;
    err_q       <= err_d;
    probe_col_q <= probe_col_d;
    wr_row_q    <= wr_row_d;
    wr_col_q    <= wr_col_d;
    wr_bit_q    <= wr_bit_d;
  end

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == glos_pkg::S_DIAG || state_q == glos_pkg::S_MAIN ||
     state_q == glos_pkg::S_SIDE0 || state_q == glos_pkg::S_SIDE1) |-> !mem_we)
    else $error("Map written during a line walk.");

  a_wait_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q |-> (state_q == glos_pkg::S_DIAG || state_q == glos_pkg::S_MAIN ||
                state_q == glos_pkg::S_SIDE0 || state_q == glos_pkg::S_SIDE1))
    else $error("Read wait flag set outside a cell test.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q != glos_pkg::S_IDLE)
    else $error("Transfer accepted without starting work.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == glos_pkg::S_DONE)
    else $error("Result presented without a finished item.");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == glos_pkg::S_CLEAR |-> !s_axis_tready_o && mem_we)
    else $error("Input taken or map not written during the clearing pass.");

endmodule

`default_nettype wire
